/* hdl/mtsed_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constants of the multitouch slot event decoder
package mtsed_pkg;

    localparam int MAX_POINTS = 2;
    localparam int SLOT_W     = 1;
    localparam int RAW_SHIFT  = 12;              // log2 of the raw axis range 4096
    localparam int PROD_W     = 44;
    localparam int MS_W       = 42;
    localparam int FRAC_W     = 11;
    localparam int RECIP_W    = 21;
    localparam int RECIP_SH   = 30;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    localparam logic signed [31:0] MAX_POINTS_VAL = 32'(MAX_POINTS);
    localparam logic signed [31:0] TRACK_RELEASE  = -32'sd1;
    localparam logic signed [31:0] PRESSURE_MAX   = 32'sd255;
    localparam logic [9:0]         MS_PER_S       = 10'd1000;
    // ceil(2^30 / 1000): exact quotient by 1000 for any 20-bit value
    localparam logic [RECIP_W-1:0] US_RECIP       = 21'd1073742;
    localparam logic [PROD_W-1:0]  ROUND_BIAS     = PROD_W'((1 << RAW_SHIFT) - 1);

    localparam logic [4:0] TYPE_SYN = 5'd0;
    localparam logic [4:0] TYPE_ABS = 5'd3;

    localparam logic [9:0] CODE_SYN_REPORT  = 10'd0;
    localparam logic [9:0] CODE_X           = 10'd0;
    localparam logic [9:0] CODE_Y           = 10'd1;
    localparam logic [9:0] CODE_PRESSURE    = 10'd24;
    localparam logic [9:0] CODE_SLOT        = 10'd47;
    localparam logic [9:0] CODE_MT_X        = 10'd53;
    localparam logic [9:0] CODE_MT_Y        = 10'd54;
    localparam logic [9:0] CODE_TRACK       = 10'd57;
    localparam logic [9:0] CODE_MT_PRESSURE = 10'd58;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_MOVE    = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 4'd1;

    localparam logic [CFG_DATA_W-1:0] PANEL_WIDTH_RST  = 12'd480;
    localparam logic [CFG_DATA_W-1:0] PANEL_HEIGHT_RST = 12'd800;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SLOT,
        OP_TRACK,
        OP_X,
        OP_Y,
        OP_PRESSURE,
        OP_SYNC
    } t_op;

    typedef struct packed {
        logic [4:0]         event_type;
        logic [9:0]         event_code;
        logic signed [31:0] event_value;
        logic [31:0]        time_seconds;
        logic [19:0]        time_microseconds;
    } t_event;

    typedef struct packed {
        t_op                      op;
        logic signed [31:0]       value;
        logic signed [PROD_W-1:0] prod;
        logic [MS_W-1:0]          ms_base;
        logic [FRAC_W-1:0]        ms_frac;
    } t_prod;

    typedef struct packed {
        logic              processed;
        logic [SLOT_W-1:0] slot_index;
        logic              slot_valid;
        logic [15:0]       slot_x;
        logic [15:0]       slot_y;
        logic [7:0]        slot_pressure;
        logic [1:0]        slot_kind;
        logic [1:0]        touch_count;
        logic [MS_W-1:0]   report_time_ms;
    } t_result;

endpackage

/* hdl/mtsed_if.sv */
`timescale 1ns / 1ps
// channel interfaces: input events, results and configuration writes
interface mtsed_event_if;
    logic               valid;
    logic               ready;
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
    logic [31:0]        time_seconds;
    logic [19:0]        time_microseconds;

    modport source (output valid, event_type, event_code, event_value, time_seconds,
                    time_microseconds, input ready);
    modport sink (input valid, event_type, event_code, event_value, time_seconds,
                  time_microseconds, output ready);
endinterface

interface mtsed_result_if;
    logic        valid;
    logic        ready;
    logic        processed;
    logic        slot_index;
    logic        slot_valid;
    logic [15:0] slot_x;
    logic [15:0] slot_y;
    logic [7:0]  slot_pressure;
    logic [1:0]  slot_kind;
    logic [1:0]  touch_count;
    logic [41:0] report_time_ms;

    modport source (output valid, processed, slot_index, slot_valid, slot_x, slot_y,
                    slot_pressure, slot_kind, touch_count, report_time_ms, input ready);
    modport sink (input valid, processed, slot_index, slot_valid, slot_x, slot_y,
                  slot_pressure, slot_kind, touch_count, report_time_ms, output ready);
endinterface

interface mtsed_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/multitouch_slot_event_decoder_unit.sv */
`timescale 1ns / 1ps
// top level of the multitouch slot event decoder
//
// i_event carries one input event per transaction (type, code, signed value,
// seconds, microseconds). every event yields exactly one transaction on
// o_result: a processed flag and the view of the current slot after the event,
// plus the touch count and millisecond timestamp of the last sync report.
// i_cfg writes panel_width (index 0) or panel_height (index 1); other indexes
// are dropped. i_cfg.ready is always high; write only while the block is idle.
// pipeline: an accepted event passes the input register, then the multiply stage,
// then the slot table / result register, which drives its result.
// throughput: one event per cycle while the receiver takes results; the slot table
// update for one event is done within its stage, so events follow each other with no gap.
// when the receiver stalls, the result register holds and the stages behind it
// keep filling; i_event.ready drops only once all three stages hold an event.
// reset (i_rst_n low, synchronous) empties the pipeline, clears the slot table,
// current slot, touch count and timestamp, and sets the panel size to 480x800.
module multitouch_slot_event_decoder_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mtsed_event_if.sink      i_event,
    mtsed_result_if.source   o_result,
    mtsed_cfg_if.sink        i_cfg
);

    logic [mtsed_pkg::CFG_DATA_W-1:0] r_width;
    logic [mtsed_pkg::CFG_DATA_W-1:0] r_height;
    logic                             r_in_valid;
    mtsed_pkg::t_event                r_in;
    mtsed_pkg::t_event                n_in;

    logic               in_en;
    logic               prod_en;
    logic               prod_valid;
    mtsed_pkg::t_prod   prod;
    logic               track_en;
    logic               res_valid;
    mtsed_pkg::t_result res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mtsed_pkg::PANEL_WIDTH_RST;
            r_height <= mtsed_pkg::PANEL_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == mtsed_pkg::CFG_PANEL_WIDTH) begin
                r_width <= i_cfg.data;
            end else if (i_cfg.index == mtsed_pkg::CFG_PANEL_HEIGHT) begin
                r_height <= i_cfg.data;
            end
        end
    end

    assign in_en         = !r_in_valid || prod_en;
    assign i_event.ready = in_en;

    always_comb begin
        n_in.event_type        = i_event.event_type;
        n_in.event_code        = i_event.event_code;
        n_in.event_value       = i_event.event_value;
        n_in.time_seconds      = i_event.time_seconds;
        n_in.time_microseconds = i_event.time_microseconds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_en) begin
            r_in_valid <= i_event.valid;
        end
        if (in_en && i_event.valid) begin
            r_in <= n_in;
        end
    end

    mtsed_prod u_prod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_event   (r_in),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_down_en (track_en),
        .o_en      (prod_en),
        .o_valid   (prod_valid),
        .o_prod    (prod)
    );

    mtsed_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (prod_valid),
        .i_prod   (prod),
        .i_ready  (o_result.ready),
        .o_en     (track_en),
        .o_valid  (res_valid),
        .o_result (res)
    );

    assign o_result.valid          = res_valid;
    assign o_result.processed      = res.processed;
    assign o_result.slot_index     = res.slot_index;
    assign o_result.slot_valid     = res.slot_valid;
    assign o_result.slot_x         = res.slot_x;
    assign o_result.slot_y         = res.slot_y;
    assign o_result.slot_pressure  = res.slot_pressure;
    assign o_result.slot_kind      = res.slot_kind;
    assign o_result.touch_count    = res.touch_count;
    assign o_result.report_time_ms = res.report_time_ms;

endmodule

/* hdl/mtsed_prod.sv */
`timescale 1ns / 1ps
// decode stage: event decode, position scaling product and timestamp products
module mtsed_prod (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  mtsed_pkg::t_event        i_event,
    input  logic [mtsed_pkg::CFG_DATA_W-1:0] i_width,
    input  logic [mtsed_pkg::CFG_DATA_W-1:0] i_height,
    input  logic                     i_down_en,
    output logic                     o_en,
    output logic                     o_valid,
    output mtsed_pkg::t_prod         o_prod
);

    logic                                    r_valid;
    mtsed_pkg::t_prod                        r_prod;
    mtsed_pkg::t_prod                        n_prod;
    logic [mtsed_pkg::CFG_DATA_W-1:0]        numer;
    logic signed [mtsed_pkg::PROD_W-1:0]     value_ext;
    logic signed [mtsed_pkg::PROD_W-1:0]     numer_ext;
    logic [mtsed_pkg::FRAC_W+mtsed_pkg::RECIP_SH-1:0] frac_prod;

    assign o_en = !r_valid || i_down_en;

    always_comb begin
        n_prod.op = mtsed_pkg::OP_NONE;
        if (i_event.event_type == mtsed_pkg::TYPE_ABS) begin
            unique case (i_event.event_code) inside
                mtsed_pkg::CODE_SLOT:  n_prod.op = mtsed_pkg::OP_SLOT;
                mtsed_pkg::CODE_TRACK: n_prod.op = mtsed_pkg::OP_TRACK;
                mtsed_pkg::CODE_X, mtsed_pkg::CODE_MT_X: n_prod.op = mtsed_pkg::OP_X;
                mtsed_pkg::CODE_Y, mtsed_pkg::CODE_MT_Y: n_prod.op = mtsed_pkg::OP_Y;
                mtsed_pkg::CODE_PRESSURE, mtsed_pkg::CODE_MT_PRESSURE: begin
                    n_prod.op = mtsed_pkg::OP_PRESSURE;
                end
                default: n_prod.op = mtsed_pkg::OP_NONE;
            endcase
        end else if (i_event.event_type == mtsed_pkg::TYPE_SYN &&
                     i_event.event_code == mtsed_pkg::CODE_SYN_REPORT) begin
            n_prod.op = mtsed_pkg::OP_SYNC;
        end

        numer     = (n_prod.op == mtsed_pkg::OP_Y) ? i_height : i_width;
        value_ext = mtsed_pkg::PROD_W'(i_event.event_value);
        numer_ext = $signed(mtsed_pkg::PROD_W'(numer));

        n_prod.value   = i_event.event_value;
        n_prod.prod    = value_ext * numer_ext;
        n_prod.ms_base = mtsed_pkg::MS_W'(i_event.time_seconds) *
                         mtsed_pkg::MS_W'(mtsed_pkg::MS_PER_S);
        // microseconds / 1000 by reciprocal multiply
        frac_prod      = (mtsed_pkg::FRAC_W + mtsed_pkg::RECIP_SH)'(i_event.time_microseconds) *
                         (mtsed_pkg::FRAC_W + mtsed_pkg::RECIP_SH)'(mtsed_pkg::US_RECIP);
        n_prod.ms_frac = frac_prod[mtsed_pkg::FRAC_W+mtsed_pkg::RECIP_SH-1:mtsed_pkg::RECIP_SH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
        if (o_en && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

/* hdl/mtsed_track.sv */
`timescale 1ns / 1ps
// slot table, sync report state and the result register
module mtsed_track (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  mtsed_pkg::t_prod   i_prod,
    input  logic               i_ready,
    output logic               o_en,
    output logic               o_valid,
    output mtsed_pkg::t_result o_result
);

    logic [mtsed_pkg::SLOT_W-1:0] r_cur;
    logic                         r_pvalid   [mtsed_pkg::MAX_POINTS];
    logic [15:0]                  r_px       [mtsed_pkg::MAX_POINTS];
    logic [15:0]                  r_py       [mtsed_pkg::MAX_POINTS];
    logic [7:0]                   r_ppress   [mtsed_pkg::MAX_POINTS];
    logic [1:0]                   r_pkind    [mtsed_pkg::MAX_POINTS];
    logic [1:0]                   r_count;
    logic [mtsed_pkg::MS_W-1:0]   r_report_ms;
    logic                         r_valid;
    mtsed_pkg::t_result           r_result;

    logic [mtsed_pkg::SLOT_W-1:0] n_cur;
    logic                         n_pvalid   [mtsed_pkg::MAX_POINTS];
    logic [15:0]                  n_px       [mtsed_pkg::MAX_POINTS];
    logic [15:0]                  n_py       [mtsed_pkg::MAX_POINTS];
    logic [7:0]                   n_ppress   [mtsed_pkg::MAX_POINTS];
    logic [1:0]                   n_pkind    [mtsed_pkg::MAX_POINTS];
    logic [1:0]                   n_count;
    logic [mtsed_pkg::MS_W-1:0]   n_report_ms;
    mtsed_pkg::t_result           n_result;

    logic [mtsed_pkg::PROD_W-1:0] rounded;
    logic [15:0]                  pos;
    logic [1:0]                   count;
    logic [mtsed_pkg::SLOT_W-1:0] s;
    logic                         update;

    assign o_en   = !r_valid || i_ready;
    assign update = o_en && i_valid;

    always_comb begin
        // truncate toward zero: round negative products up before the shift
        rounded = i_prod.prod + (i_prod.prod[mtsed_pkg::PROD_W-1] ? mtsed_pkg::ROUND_BIAS
                                                                   : '0);
        pos     = rounded[mtsed_pkg::RAW_SHIFT+15:mtsed_pkg::RAW_SHIFT];
        count   = '0;
        for (int i = 0; i < mtsed_pkg::MAX_POINTS; i++) begin
            count = count + 2'(r_pvalid[i]);
        end

        s           = r_cur;
        n_cur       = r_cur;
        n_pvalid    = r_pvalid;
        n_px        = r_px;
        n_py        = r_py;
        n_ppress    = r_ppress;
        n_pkind     = r_pkind;
        n_count     = r_count;
        n_report_ms = r_report_ms;
        n_result.processed = 1'b0;

        unique case (i_prod.op)
            mtsed_pkg::OP_SLOT: begin
                if (i_prod.value >= 0 && i_prod.value < mtsed_pkg::MAX_POINTS_VAL) begin
                    n_cur = i_prod.value[mtsed_pkg::SLOT_W-1:0];
                end else begin
                    n_cur = '0;
                end
            end
            mtsed_pkg::OP_TRACK: begin
                if (i_prod.value == mtsed_pkg::TRACK_RELEASE) begin
                    n_pvalid[s] = 1'b0;
                    n_pkind[s]  = mtsed_pkg::KIND_RELEASE;
                end else begin
                    n_pvalid[s] = 1'b1;
                    n_pkind[s]  = mtsed_pkg::KIND_PRESS;
                end
                n_result.processed = 1'b1;
            end
            mtsed_pkg::OP_X: begin
                n_px[s] = pos;
                if (r_pvalid[s]) begin
                    n_pkind[s]         = mtsed_pkg::KIND_MOVE;
                    n_result.processed = 1'b1;
                end
            end
            mtsed_pkg::OP_Y: begin
                n_py[s] = pos;
                if (r_pvalid[s]) begin
                    n_pkind[s]         = mtsed_pkg::KIND_MOVE;
                    n_result.processed = 1'b1;
                end
            end
            mtsed_pkg::OP_PRESSURE: begin
                if (i_prod.value > mtsed_pkg::PRESSURE_MAX) begin
                    n_ppress[s] = 8'hFF;
                end else begin
                    n_ppress[s] = i_prod.value[7:0];
                end
            end
            mtsed_pkg::OP_SYNC: begin
                n_count            = count;
                n_report_ms        = i_prod.ms_base + mtsed_pkg::MS_W'(i_prod.ms_frac);
                n_result.processed = 1'b1;
            end
            default: begin
            end
        endcase

        n_result.slot_index     = n_cur;
        n_result.slot_valid     = n_pvalid[n_cur];
        n_result.slot_x         = n_px[n_cur];
        n_result.slot_y         = n_py[n_cur];
        n_result.slot_pressure  = n_ppress[n_cur];
        n_result.slot_kind      = n_pkind[n_cur];
        n_result.touch_count    = n_count;
        n_result.report_time_ms = n_report_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_cur       <= '0;
            r_count     <= '0;
            r_report_ms <= '0;
            for (int i = 0; i < mtsed_pkg::MAX_POINTS; i++) begin
                r_pvalid[i] <= 1'b0;
                r_px[i]     <= '0;
                r_py[i]     <= '0;
                r_ppress[i] <= '0;
                r_pkind[i]  <= mtsed_pkg::KIND_NONE;
            end
        end else begin
            if (o_en) begin
                r_valid <= i_valid;
            end
            if (update) begin
                r_cur       <= n_cur;
                r_pvalid    <= n_pvalid;
                r_px        <= n_px;
                r_py        <= n_py;
                r_ppress    <= n_ppress;
                r_pkind     <= n_pkind;
                r_count     <= n_count;
                r_report_ms <= n_report_ms;
            end
        end
        if (update) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* tb/sv/tb_multitouch_slot_event_decoder_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench of the multitouch slot event decoder: directed and random event traffic
module tb_multitouch_slot_event_decoder_unit;
    import mtsed_pkg::*;

    localparam int     STUCK_LIMIT     = 2000;
    localparam int     DRAIN_CYCLES    = 8;
    localparam int     PRINT_LIMIT     = 40;
    localparam int     ITEMS_PER_PHASE = 240;
    localparam longint RAW_RANGE       = longint'(1) << RAW_SHIFT;

    // codes the block has to ignore
    localparam logic [4:0]           TYPE_MAX         = 5'd31;
    localparam logic [9:0]           CODE_MAX         = 10'd1023;
    localparam logic [9:0]           CODE_SYN_DROPPED = 10'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX   = 4'd15;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    typedef enum {SINK_ALWAYS, SINK_RANDOM, SINK_RUNS} t_sink_mode;

    logic i_clk;
    logic i_rst_n;

    mtsed_event_if  evt_ch ();
    mtsed_result_if res_ch ();
    mtsed_cfg_if    cfg_ch ();

    multitouch_slot_event_decoder_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (evt_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // expected slot tracker state
    logic [SLOT_W-1:0]     trk_slot;
    logic                  pt_valid [MAX_POINTS];
    logic [15:0]           pt_x     [MAX_POINTS];
    logic [15:0]           pt_y     [MAX_POINTS];
    logic [7:0]            pt_pres  [MAX_POINTS];
    logic [1:0]            pt_kind  [MAX_POINTS];
    logic [1:0]            trk_count;
    logic [MS_W-1:0]       trk_report_ms;
    logic [CFG_DATA_W-1:0] panel_w;
    logic [CFG_DATA_W-1:0] panel_h;

    t_result touch_view_q [$];

    int          mismatch_count;
    int          results_checked;
    int          processed_seen;
    int          panel_writes;
    int          events_sent;
    int          stuck_cycles;
    int          burst_left;
    int unsigned gap_max;
    int unsigned stall_pct;
    t_sink_mode  sink_mode;
    bit          sink_stalled;
    int          run_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [19:0] rand_usecs();
        if ($urandom_range(7) == 0)
            return 20'($urandom);
        return 20'($urandom_range(0, 999999));
    endfunction

    function automatic logic signed [31:0] rand_axis();
        if ($urandom_range(5) == 0)
            return $urandom;
        return 32'($urandom_range(0, 4095));
    endfunction

    // axis value times panel size over the raw range, truncated toward zero, low 16 bits
    function automatic logic [15:0] scale_axis(input logic signed [31:0] value,
                                               input logic [CFG_DATA_W-1:0] numer);
        longint q;
        q = (longint'(value) * longint'({1'b0, numer})) / RAW_RANGE;
        return q[15:0];
    endfunction

    function automatic t_result predict_touch_view(input t_event ev);
        t_result           r;
        logic [SLOT_W-1:0] s;
        longint            val;
        longint unsigned   ms;
        int                n;
        s = trk_slot;
        val = longint'($signed(ev.event_value));
        r.processed = 1'b0;
        if (ev.event_type == TYPE_ABS) begin
            case (ev.event_code)
                CODE_SLOT: begin
                    if (val < 0 || val >= longint'(MAX_POINTS))
                        trk_slot = '0;
                    else
                        trk_slot = val[SLOT_W-1:0];
                end
                CODE_TRACK: begin
                    if ($signed(ev.event_value) == TRACK_RELEASE) begin
                        pt_valid[s] = 1'b0;
                        pt_kind[s]  = KIND_RELEASE;
                    end else begin
                        pt_valid[s] = 1'b1;
                        pt_kind[s]  = KIND_PRESS;
                    end
                    r.processed = 1'b1;
                end
                CODE_X, CODE_MT_X: begin
                    pt_x[s] = scale_axis(ev.event_value, panel_w);
                    if (pt_valid[s]) begin
                        pt_kind[s]  = KIND_MOVE;
                        r.processed = 1'b1;
                    end
                end
                CODE_Y, CODE_MT_Y: begin
                    pt_y[s] = scale_axis(ev.event_value, panel_h);
                    if (pt_valid[s]) begin
                        pt_kind[s]  = KIND_MOVE;
                        r.processed = 1'b1;
                    end
                end
                CODE_PRESSURE, CODE_MT_PRESSURE: begin
                    if (val > longint'(PRESSURE_MAX))
                        pt_pres[s] = PRESSURE_MAX[7:0];
                    else
                        pt_pres[s] = ev.event_value[7:0];
                end
                default: ;
            endcase
        end else if (ev.event_type == TYPE_SYN && ev.event_code == CODE_SYN_REPORT) begin
            n = 0;
            for (int i = 0; i < MAX_POINTS; i++)
                if (pt_valid[i])
                    n++;
            trk_count = n[1:0];
            ms = 64'(ev.time_seconds) * 64'(MS_PER_S) + 64'(ev.time_microseconds) / 64'(MS_PER_S);
            trk_report_ms = ms[MS_W-1:0];
            r.processed = 1'b1;
        end
        r.slot_index     = trk_slot;
        r.slot_valid     = pt_valid[trk_slot];
        r.slot_x         = pt_x[trk_slot];
        r.slot_y         = pt_y[trk_slot];
        r.slot_pressure  = pt_pres[trk_slot];
        r.slot_kind      = pt_kind[trk_slot];
        r.touch_count    = trk_count;
        r.report_time_ms = trk_report_ms;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s expected 0x%0h got 0x%0h",
                                      results_checked, name, want, got));
    endtask

    // config, event and result transactions, in that order so a same-edge result still finds its entry
    always @(posedge i_clk) begin : result_check
        t_event  seen;
        t_result want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                panel_writes++;
                case (cfg_ch.index)
                    CFG_PANEL_WIDTH:  panel_w = cfg_ch.data;
                    CFG_PANEL_HEIGHT: panel_h = cfg_ch.data;
                    default: ;
                endcase
            end
            if (evt_ch.valid && evt_ch.ready) begin
                seen.event_type        = evt_ch.event_type;
                seen.event_code        = evt_ch.event_code;
                seen.event_value       = evt_ch.event_value;
                seen.time_seconds      = evt_ch.time_seconds;
                seen.time_microseconds = evt_ch.time_microseconds;
                want = predict_touch_view(seen);
                if (want.processed)
                    processed_seen++;
                touch_view_q.push_back(want);
            end
            if (res_ch.valid && res_ch.ready) begin
                if (touch_view_q.size() == 0) begin
                    report_mismatch("result with no event outstanding");
                end else begin
                    want = touch_view_q.pop_front();
                    check_field("processed", 64'(want.processed), 64'(res_ch.processed));
                    check_field("slot_index", 64'(want.slot_index), 64'(res_ch.slot_index));
                    check_field("slot_valid", 64'(want.slot_valid), 64'(res_ch.slot_valid));
                    check_field("slot_x", 64'(want.slot_x), 64'(res_ch.slot_x));
                    check_field("slot_y", 64'(want.slot_y), 64'(res_ch.slot_y));
                    check_field("slot_pressure", 64'(want.slot_pressure),
                                64'(res_ch.slot_pressure));
                    check_field("slot_kind", 64'(want.slot_kind), 64'(res_ch.slot_kind));
                    check_field("touch_count", 64'(want.touch_count), 64'(res_ch.touch_count));
                    check_field("report_time_ms", 64'(want.report_time_ms),
                                64'(res_ch.report_time_ms));
                end
                results_checked++;
            end
        end
    end

    always @(negedge i_clk) begin : result_sink
        case (sink_mode)
            SINK_ALWAYS: res_ch.ready <= 1'b1;
            SINK_RANDOM: res_ch.ready <= ($urandom_range(99) >= stall_pct);
            default: begin
                if (run_left == 0) begin
                    sink_stalled = !sink_stalled;
                    run_left = sink_stalled ? $urandom_range(1, 16) : $urandom_range(1, 24);
                end
                run_left--;
                res_ch.ready <= !sink_stalled;
            end
        endcase
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stuck_cycles, touch_view_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // one event transaction; the sender runs in bursts with random gaps between them
    task automatic send_event(input logic [4:0] etype, input logic [9:0] ecode,
                              input logic signed [31:0] evalue, input logic [31:0] secs,
                              input logic [19:0] usecs);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(gap_max);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge i_clk);
                evt_ch.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        evt_ch.valid             <= 1'b1;
        evt_ch.event_type        <= etype;
        evt_ch.event_code        <= ecode;
        evt_ch.event_value       <= evalue;
        evt_ch.time_seconds      <= secs;
        evt_ch.time_microseconds <= usecs;
        do @(posedge i_clk); while (!evt_ch.ready);
        events_sent++;
    endtask

    task automatic send_abs(input logic [9:0] ecode, input logic signed [31:0] evalue);
        send_event(TYPE_ABS, ecode, evalue, $urandom, rand_usecs());
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        evt_ch.valid <= 1'b0;
        while (touch_view_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_panel(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_ignored_events();
        send_event(TYPE_MAX, CODE_MAX, INT_MAX, '1, '1);
        send_abs(CODE_MAX, INT_MIN);
        send_event(TYPE_SYN, CODE_SYN_DROPPED, 32'sd5, $urandom, rand_usecs());
    endtask

    task automatic test_slot_select();
        send_abs(CODE_SLOT, -32'sd5);
        send_abs(CODE_SLOT, MAX_POINTS_VAL);
        send_abs(CODE_SLOT, 32'sd1);
    endtask

    task automatic test_tracking_id();
        send_abs(CODE_TRACK, 32'sd0);
        send_abs(CODE_TRACK, TRACK_RELEASE);
        // position on a released slot is stored but not a move
        send_abs(CODE_MT_X, 32'sd2000);
    endtask

    task automatic test_position_scaling();
        send_abs(CODE_TRACK, INT_MIN);
        send_abs(CODE_MT_X, INT_MAX);
        send_abs(CODE_X, INT_MIN);
        send_abs(CODE_MT_Y, -32'sd1);
        send_abs(CODE_Y, 32'sd4095);
    endtask

    task automatic test_pressure_clamp();
        send_abs(CODE_PRESSURE, PRESSURE_MAX);
        send_abs(CODE_MT_PRESSURE, PRESSURE_MAX + 32'sd1);
        send_abs(CODE_PRESSURE, -32'sd1);
        send_abs(CODE_MT_PRESSURE, INT_MIN);
    endtask

    task automatic test_sync_report();
        send_abs(CODE_SLOT, 32'sd0);
        send_abs(CODE_TRACK, 32'sd7);
        send_event(TYPE_SYN, CODE_SYN_REPORT, INT_MIN, '1, 20'd999999);
        send_event(TYPE_SYN, CODE_SYN_REPORT, 32'sd0, 32'd0, '1);
        send_event(TYPE_SYN, CODE_SYN_REPORT, 32'sd0, 32'd0, 20'd0);
    endtask

    task automatic test_panel_config();
        wait_idle();
        write_panel(CFG_PANEL_WIDTH, 12'd4095);
        write_panel(CFG_PANEL_HEIGHT, 12'd1);
        send_abs(CODE_MT_X, 32'sd4095);
        send_abs(CODE_MT_Y, INT_MAX);
        wait_idle();
        write_panel(CFG_PANEL_WIDTH, 12'd1);
        write_panel(CFG_PANEL_HEIGHT, 12'd4095);
        write_panel(CFG_UNUSED_IDX, 12'd123);
        send_abs(CODE_X, -32'sd4096);
        send_abs(CODE_Y, 32'sd4095);
    endtask

    // slot, tracking id, position, pressure and report, each part sometimes left out
    task automatic send_touch_frame(output int n_sent);
        logic signed [31:0] slot_val;
        logic signed [31:0] track_val;
        n_sent = 0;
        if ($urandom_range(7) == 0)
            slot_val = $urandom;
        else
            slot_val = 32'($urandom_range(0, MAX_POINTS - 1));
        if ($urandom_range(3) == 0)
            track_val = TRACK_RELEASE;
        else if ($urandom_range(9) == 0)
            track_val = $urandom;
        else
            track_val = 32'($urandom_range(0, 9999));
        if ($urandom_range(4) != 0) begin
            send_abs(CODE_SLOT, slot_val);
            n_sent++;
        end
        if ($urandom_range(2) == 0) begin
            send_abs(CODE_TRACK, track_val);
            n_sent++;
        end
        if ($urandom_range(4) != 0) begin
            send_abs($urandom_range(1) ? CODE_MT_X : CODE_X, rand_axis());
            n_sent++;
        end
        if ($urandom_range(4) != 0) begin
            send_abs($urandom_range(1) ? CODE_MT_Y : CODE_Y, rand_axis());
            n_sent++;
        end
        if ($urandom_range(2) != 0) begin
            send_abs($urandom_range(1) ? CODE_MT_PRESSURE : CODE_PRESSURE,
                     ($urandom_range(5) == 0) ? $urandom : 32'($urandom_range(0, 300)));
            n_sent++;
        end
        if ($urandom_range(5) != 0) begin
            send_event(TYPE_SYN, CODE_SYN_REPORT, $urandom, $urandom, rand_usecs());
            n_sent++;
        end
    endtask

    task automatic test_random_traffic();
        int frame_items;
        int n;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_panel(CFG_PANEL_WIDTH, 12'd4095);
                    write_panel(CFG_PANEL_HEIGHT, 12'd4095);
                    gap_max   = 0;
                    sink_mode = SINK_ALWAYS;
                end
                1: begin
                    write_panel(CFG_PANEL_WIDTH, 12'd1);
                    write_panel(CFG_PANEL_HEIGHT, 12'd1);
                    gap_max   = 6;
                    stall_pct = 30;
                    sink_mode = SINK_RANDOM;
                end
                2: begin
                    write_panel(CFG_PANEL_WIDTH, 12'($urandom_range(1, 4095)));
                    write_panel(CFG_PANEL_HEIGHT, 12'($urandom_range(1, 4095)));
                    gap_max   = 3;
                    sink_mode = SINK_RUNS;
                end
                default: begin
                    write_panel(CFG_PANEL_WIDTH, PANEL_WIDTH_RST);
                    write_panel(CFG_PANEL_HEIGHT, PANEL_HEIGHT_RST);
                    gap_max   = 12;
                    stall_pct = 60;
                    sink_mode = SINK_RANDOM;
                end
            endcase
            frame_items = 0;
            while (frame_items < ITEMS_PER_PHASE) begin
                if ($urandom_range(4) == 0) begin
                    // noise: mostly ignored types and codes
                    send_event(($urandom_range(1) == 0) ? TYPE_ABS : 5'($urandom), 10'($urandom),
                               $urandom, $urandom, rand_usecs());
                end else begin
                    send_touch_frame(n);
                    frame_items += n;
                end
            end
        end
    endtask

    initial begin
        i_rst_n                  = 1'b0;
        evt_ch.valid             = 1'b0;
        evt_ch.event_type        = '0;
        evt_ch.event_code        = '0;
        evt_ch.event_value       = '0;
        evt_ch.time_seconds      = '0;
        evt_ch.time_microseconds = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = '0;
        cfg_ch.data              = '0;
        res_ch.ready             = 1'b0;
        trk_slot                 = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            pt_valid[i] = 1'b0;
            pt_x[i]     = '0;
            pt_y[i]     = '0;
            pt_pres[i]  = '0;
            pt_kind[i]  = KIND_NONE;
        end
        trk_count       = '0;
        trk_report_ms   = '0;
        panel_w         = PANEL_WIDTH_RST;
        panel_h         = PANEL_HEIGHT_RST;
        mismatch_count  = 0;
        results_checked = 0;
        processed_seen  = 0;
        panel_writes    = 0;
        events_sent     = 0;
        stuck_cycles    = 0;
        burst_left      = 0;
        gap_max         = 3;
        stall_pct       = 25;
        sink_mode       = SINK_RANDOM;
        sink_stalled    = 1'b0;
        run_left        = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ignored_events();
        test_slot_select();
        test_tracking_id();
        test_position_scaling();
        test_pressure_clamp();
        test_sync_report();
        test_panel_config();
        test_random_traffic();
        wait_idle();

        $display("%0d events sent, %0d results checked, %0d of them updated touch data",
                 events_sent, results_checked, processed_seen);
        $display("%0d panel size writes, %0d mismatches", panel_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mtsed_pkg.sv
hdl/mtsed_if.sv
hdl/mtsed_prod.sv
hdl/mtsed_track.sv
hdl/multitouch_slot_event_decoder_unit.sv
tb/sv/tb_multitouch_slot_event_decoder_unit.sv
